// ===== rtl/core/window_weight_argmax_filter_macros.svh =====
// assertion macros shared by the window argmax filter rtl
`ifndef WINDOW_WEIGHT_ARGMAX_FILTER_MACROS_SVH
`define WINDOW_WEIGHT_ARGMAX_FILTER_MACROS_SVH

// expression must hold at every clock edge outside reset
`define WWAF_CHECK(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("wwaf check failed");

// consequent must hold in the cycle after the antecedent
`define WWAF_CHECK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wwaf sequence check failed");

`endif

// ===== rtl/core/wwaf_pkg.sv =====
// shared types and constants of the window argmax filter
`default_nettype none

package wwaf_pkg;

    // default build parameters
    localparam int DEF_MAX_RADIUS = 3;
    localparam int DEF_MAX_WIDTH  = 1024;

    // pixel field widths
    localparam int WEIGHT_W = 16;
    localparam int ID_W     = 8;
    localparam int PIX_W    = WEIGHT_W + ID_W;

    // configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 13;
    localparam int RADIUS_W   = 2;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 13;
    localparam int HEIGHT_MAX = 4096;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_RADIUS = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_HEIGHT = 2'd2;

    // reset values
    localparam int RST_RADIUS = 1;
    localparam int RST_WIDTH  = 1024;
    localparam int RST_HEIGHT = 768;

    // one stored pixel, weight above id
    typedef struct packed {
        logic [WEIGHT_W-1:0] weight;
        logic [ID_W-1:0]     id;
    } t_pix;

    // per item control carried alongside the window
    typedef struct packed {
        logic            emit;
        logic            interior;
        logic            frame_end;
        logic [ID_W-1:0] own_id;
    } t_side;

endpackage

`default_nettype wire

// ===== rtl/core/wwaf_ram.sv =====
// generic single write port ram with registered read
`default_nettype none

module wwaf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old word on a same address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/core/wwaf_argmax_tree.sv =====
// pipelined argmax compare tree over the window, first pixel wins ties
`default_nettype none

module wwaf_argmax_tree
    import wwaf_pkg::*;
#(
    parameter int MAX_RADIUS = DEF_MAX_RADIUS,
    localparam int K  = 2 * MAX_RADIUS + 1,
    localparam int RW = $clog2(MAX_RADIUS + 1)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_adv,
    input  wire logic                  i_valid,
    input  wire t_side                 i_side,
    input  wire t_pix [K-1:0][K-1:0]   i_win,
    input  wire logic [RW-1:0]         i_radius,
    output logic                       o_valid,
    output t_side                      o_side,
    output t_pix                       o_best
);

    localparam int N  = K * K;
    localparam int LV = $clog2(N);
    localparam int NP = 1 << LV;

    // later operand wins only on a strictly greater weight
    function automatic t_pix f_pick(input t_pix a, input t_pix b);
        return (b.weight > a.weight) ? b : a;
    endfunction

    logic [RW:0]     w_span;
    t_pix            w_leaf [NP];
    t_pix            r_node [1:NP-1];
    logic [LV-1:0]   r_vpipe;
    t_side           r_spipe [LV];

    assign w_span = {i_radius, 1'b0};

    // leaves in row-major window order, pixels outside the radius masked off
    for (genvar n = 0; n < NP; n++) begin : g_leaf
        if (n < N) begin : g_pix
            localparam int ROW = n / K;
            localparam int COL = n % K;
            localparam int A   = 2 * MAX_RADIUS - ROW;
            localparam int B   = 2 * MAX_RADIUS - COL;
            assign w_leaf[n] = ((RW+1)'(A) <= w_span && (RW+1)'(B) <= w_span)
                               ? i_win[A][B] : '0;
        end else begin : g_pad
            assign w_leaf[n] = '0;
        end
    end

    // heap ordered nodes, one register stage per tree level
    for (genvar i = 1; i < NP; i++) begin : g_node
        t_pix w_left;
        t_pix w_right;
        if (2 * i >= NP) begin : g_bottom
            assign w_left  = w_leaf[2*i-NP];
            assign w_right = w_leaf[2*i+1-NP];
        end else begin : g_inner
            assign w_left  = r_node[2*i];
            assign w_right = r_node[2*i+1];
        end
        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_node[i] <= f_pick(w_left, w_right);
            end
        end
    end

    // valid bits follow the tree depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vpipe <= '0;
        end else if (i_adv) begin
            r_vpipe <= {r_vpipe[LV-2:0], i_valid};
        end
    end

    // control follows the tree depth
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_spipe[0] <= i_side;
            for (int k = 1; k < LV; k++) begin
                r_spipe[k] <= r_spipe[k-1];
            end
        end
    end

    assign o_valid = r_vpipe[LV-1];
    assign o_side  = r_spipe[LV-1];
    assign o_best  = r_node[1];

endmodule

`default_nettype wire

// ===== rtl/core/window_weight_argmax_filter.sv =====
// top level of the sliding window weighted argmax filter
//
// Input stream s_axis carries one raster pixel per transfer: a 16 bit focus
// weight and an 8 bit source id. After each frame the source sends
// radius*width+radius filler transfers whose data is ignored; they push out
// the last delayed results. Output stream m_axis carries one result per
// transfer: the id of the heaviest pixel in the (2r+1) square window around
// the pixel, or the pixel's own id within r of a frame edge; tlast marks the
// frame's last pixel. Results leave in raster order, r rows plus r pixels of
// transfers behind the input.
// One transfer is accepted every clock while the receiver does not stall.
// A released result passes stage a, stage b, the compare tree of depth
// LV = ceil(log2((2*MAX_RADIUS+1)^2)) and the output register. The line
// buffer ram has MAX_WIDTH words. The user must write the config port only
// while the block is idle; the block itself does not enforce it. Any write
// of a listed register restarts the frame. Reset loads radius 1, width
// 1024, height 768 and restarts the frame. A stalled receiver freezes the
// whole pipe and drops s_axis_tready in the same clock.
`default_nettype none
`include "window_weight_argmax_filter_macros.svh"

module window_weight_argmax_filter
    import wwaf_pkg::*;
#(
    parameter int MAX_RADIUS = DEF_MAX_RADIUS,
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // config write port
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // pixel stream in
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [23:0]           s_axis_tdata,   // focus_weight[15:0], source_id[23:16]
    // result stream out
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [7:0]                 m_axis_tdata,   // filtered_id[7:0]
    output logic                       m_axis_tlast
);

    localparam int K    = 2 * MAX_RADIUS + 1;
    localparam int KIW  = $clog2(K);
    localparam int RW   = $clog2(MAX_RADIUS + 1);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int QYW  = $clog2(HEIGHT_MAX);
    localparam int DW   = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
    localparam int LBR  = 2 * MAX_RADIUS;
    localparam int LBW  = LBR * PIX_W;
    localparam int RST_W = (RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_WIDTH;
    localparam int RST_R = (RST_RADIUS > MAX_RADIUS) ? MAX_RADIUS : RST_RADIUS;

    // configuration, held as saturated values
    logic [RW-1:0]       r_rad, n_rad;
    logic [WW-1:0]       r_wid, n_wid;
    logic [HEIGHT_W-1:0] r_hgt, n_hgt;

    // stream position
    logic [DW-1:0]       r_pre, n_pre;
    logic [CW-1:0]       r_qx, n_qx;
    logic [QYW-1:0]      r_qy, n_qy;
    logic [CW-1:0]       r_col, n_col;

    logic                w_adv;
    logic                w_accept;
    logic [DW-1:0]       w_delay;
    logic                w_last_col;
    t_pix                w_in_pix;
    t_side               w_in_side;

    // stage a: input register and line buffer read
    logic                r_a_valid;
    t_pix                r_a_pix;
    t_side               r_a_side;
    logic [CW-1:0]       r_a_col;
    logic                r_a_fwd;
    logic [LBW-1:0]      r_fwd_data;
    logic [LBW-1:0]      w_ram_q;
    t_pix [LBR-1:0]      w_rows;
    t_pix [LBR-1:0]      w_wr_vec;
    t_pix [K-1:0]        w_col;

    // stage b: window
    logic                r_b_valid;
    t_side               r_b_side;
    t_side               w_b_side;
    t_pix [K-1:0][K-1:0] r_win;
    logic [KIW-1:0]      w_ctr_idx;

    // tree and output register
    logic                w_t_valid;
    t_side               w_t_side;
    t_pix                w_t_best;
    logic                r_out_valid;
    logic [ID_W-1:0]     r_out_id;
    logic                r_out_last;

    // handshake: the pipe moves unless a result is held back
    assign w_adv         = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_adv;
    assign w_accept      = s_axis_tvalid && w_adv;

    assign w_in_pix.weight = s_axis_tdata[15:0];
    assign w_in_pix.id     = s_axis_tdata[23:16];

    // output delay in transfers, r*w + r
    assign w_delay    = DW'(r_rad) * DW'(r_wid) + DW'(r_rad);
    assign w_last_col = (r_col == CW'(r_wid - WW'(1)));

    // control of the result this transfer releases
    always_comb begin
        w_in_side.emit      = (r_pre == w_delay);
        w_in_side.interior  = ((WW+1)'(r_qx) >= (WW+1)'(r_rad))
                              && ((WW+1)'(r_qx) + (WW+1)'(r_rad) < (WW+1)'(r_wid))
                              && (HEIGHT_W'(r_qy) >= HEIGHT_W'(r_rad))
                              && (HEIGHT_W'(r_qy) + HEIGHT_W'(r_rad) < r_hgt);
        w_in_side.frame_end = (r_qx == CW'(r_wid - WW'(1)))
                              && (r_qy == QYW'(r_hgt - HEIGHT_W'(1)));
        w_in_side.own_id    = '0;
    end

    // config writes and stream counters
    always_comb begin
        n_rad = r_rad;
        n_wid = r_wid;
        n_hgt = r_hgt;
        n_pre = r_pre;
        n_qx  = r_qx;
        n_qy  = r_qy;
        n_col = r_col;
        if (i_cfg_we && i_cfg_addr != 2'd3) begin
            n_pre = '0;
            n_qx  = '0;
            n_qy  = '0;
            n_col = '0;
            unique case (i_cfg_addr)
                CFG_RADIUS: begin
                    if (32'(i_cfg_wdata[RADIUS_W-1:0]) > MAX_RADIUS) begin
                        n_rad = RW'(MAX_RADIUS);
                    end else begin
                        n_rad = RW'(i_cfg_wdata[RADIUS_W-1:0]);
                    end
                end
                CFG_WIDTH: begin
                    if (i_cfg_wdata[WIDTH_W-1:0] == '0) begin
                        n_wid = WW'(1);
                    end else if (32'(i_cfg_wdata[WIDTH_W-1:0]) > MAX_WIDTH) begin
                        n_wid = WW'(MAX_WIDTH);
                    end else begin
                        n_wid = WW'(i_cfg_wdata[WIDTH_W-1:0]);
                    end
                end
                CFG_HEIGHT: begin
                    if (i_cfg_wdata[HEIGHT_W-1:0] == '0) begin
                        n_hgt = HEIGHT_W'(1);
                    end else if (32'(i_cfg_wdata[HEIGHT_W-1:0]) > HEIGHT_MAX) begin
                        n_hgt = HEIGHT_W'(HEIGHT_MAX);
                    end else begin
                        n_hgt = i_cfg_wdata[HEIGHT_W-1:0];
                    end
                end
                default: begin
                    n_rad = r_rad;
                end
            endcase
        end else if (w_accept) begin
            n_col = w_last_col ? '0 : r_col + CW'(1);
            if (w_in_side.emit) begin
                if (w_in_side.frame_end) begin
                    n_pre = '0;
                    n_qx  = '0;
                    n_qy  = '0;
                end else if (r_qx == CW'(r_wid - WW'(1))) begin
                    n_qx = '0;
                    n_qy = r_qy + QYW'(1);
                end else begin
                    n_qx = r_qx + CW'(1);
                end
            end else begin
                n_pre = r_pre + DW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rad <= RW'(RST_R);
            r_wid <= WW'(RST_W);
            r_hgt <= HEIGHT_W'(RST_HEIGHT);
            r_pre <= '0;
            r_qx  <= '0;
            r_qy  <= '0;
            r_col <= '0;
        end else begin
            r_rad <= n_rad;
            r_wid <= n_wid;
            r_hgt <= n_hgt;
            r_pre <= n_pre;
            r_qx  <= n_qx;
            r_qy  <= n_qy;
            r_col <= n_col;
        end
    end

    // line buffer: each word holds the column's older rows, newest first
    wwaf_ram #(
        .WIDTH (LBW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (r_a_valid && w_adv),
        .i_waddr (r_a_col),
        .i_wdata (w_wr_vec),
        .i_re    (w_accept),
        .i_raddr (r_col),
        .o_rdata (w_ram_q)
    );

    // same address write in the read cycle is bypassed (one pixel rows)
    assign w_rows   = r_a_fwd ? r_fwd_data : w_ram_q;
    assign w_wr_vec = {w_rows[LBR-2:0], r_a_pix};

    always_comb begin
        w_col[0] = r_a_pix;
        for (int a = 1; a < K; a++) begin
            w_col[a] = w_rows[a-1];
        end
    end

    // stage a registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_adv) begin
            r_a_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a_pix    <= w_in_pix;
            r_a_side   <= w_in_side;
            r_a_col    <= r_col;
            r_a_fwd    <= r_a_valid && (r_col == r_a_col);
            r_fwd_data <= w_wr_vec;
        end
    end

    // stage b: window shifts one column per transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_adv) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_a_valid) begin
            r_b_side <= r_a_side;
            for (int a = 0; a < K; a++) begin
                r_win[a][0] <= w_col[a];
                for (int b = 1; b < K; b++) begin
                    r_win[a][b] <= r_win[a][b-1];
                end
            end
        end
    end

    // window center gives the pass-through id
    assign w_ctr_idx = KIW'(r_rad);

    always_comb begin
        w_b_side        = r_b_side;
        w_b_side.own_id = r_win[w_ctr_idx][w_ctr_idx].id;
    end

    wwaf_argmax_tree #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_tree (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_valid  (r_b_valid),
        .i_side   (w_b_side),
        .i_win    (r_win),
        .i_radius (r_rad),
        .o_valid  (w_t_valid),
        .o_side   (w_t_side),
        .o_best   (w_t_best)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_t_valid && w_t_side.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (!w_t_side.interior) begin
                r_out_id <= w_t_side.own_id;
            end else if (w_t_best.weight == '0) begin
                r_out_id <= '0;
            end else begin
                r_out_id <= w_t_best.id;
            end
            r_out_last <= w_t_side.frame_end;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_id;
    assign m_axis_tlast  = r_out_last;

    // counters stay inside the frame geometry
    `WWAF_CHECK(a_pre_in_range, i_clk, i_rst_n, r_pre <= w_delay)
    `WWAF_CHECK(a_qx_in_range, i_clk, i_rst_n, (WW+1)'(r_qx) < (WW+1)'(r_wid))
    `WWAF_CHECK(a_qy_in_range, i_clk, i_rst_n, HEIGHT_W'(r_qy) < r_hgt)
    `WWAF_CHECK(a_col_in_range, i_clk, i_rst_n, (WW+1)'(r_col) < (WW+1)'(r_wid))
    // the frame's last result restarts the period
    `WWAF_CHECK_NEXT(a_frame_wrap, i_clk, i_rst_n,
        w_accept && w_in_side.emit && w_in_side.frame_end && !i_cfg_we,
        r_pre == '0 && r_qx == '0 && r_qy == '0)

endmodule

`default_nettype wire
